### rtl/a85_pkg.sv
// a85_pkg: shared types, constants and helper functions of the ascii85 encoder
// no dependencies; imported by every module under rtl
package a85_pkg;

	// reciprocal of 85 scaled by 2**38, exact for every 32-bit dividend
	localparam logic [31:0] RECIP_85 = 32'd3233857729;
	localparam int unsigned RECIP_SHIFT = 38;

	localparam logic [7:0] ASCII_BASE = 8'd33;
	localparam logic [7:0] ZERO_CHAR = 8'h7a;

	localparam int unsigned QUEUE_DEPTH = 2;

	// z85 alphabet, first character in the most significant byte
	localparam logic [85*8-1:0] Z85_ALPHABET =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

	// closed group between front and back
	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  pos;   // bytes in group minus one
		logic        eom;
		logic        zero;  // full group of zero bytes
	} grp_t;

	// five base-85 digits, least significant first, plus group info
	typedef struct packed {
		logic [4:0][6:0] digit;
		logic [1:0]      pos;
		logic            eom;
		logic            zero;
	} dig_t;

	// quotient by 85
	function automatic logic [31:0] div85(input logic [31:0] x);
		logic [63:0] prod;
		prod = {32'b0, x} * {32'b0, RECIP_85};
		return 32'(prod >> RECIP_SHIFT);
	endfunction

	// remainder a - 85*b, valid when b is the quotient of a by 85
	function automatic logic [6:0] rem85(input logic [31:0] a, input logic [31:0] b);
		logic [6:0] t;
		t = {b[0], 6'b0} + {b[2:0], 4'b0} + {b[4:0], 2'b0} + b[6:0];
		return a[6:0] - t;
	endfunction

	// z85 table lookup
	function automatic logic [7:0] z85_char(input logic [6:0] d);
		logic [6:0] k;
		k = 7'd84 - d;
		return Z85_ALPHABET[{k, 3'b000} +: 8];
	endfunction

endpackage

### rtl/a85_front.sv
// a85_front: packs input bytes big-endian into groups and closes them
// depends on a85_pkg; feeds a85_queue
module a85_front
	import a85_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       q_full,
	output logic       q_push,
	output grp_t       q_entry
);

	logic [31:0] group_q;
	logic [1:0]  pos_q;
	logic        accept;
	logic        close;
	logic [31:0] word;

	assign full   = q_full;
	assign accept = push && !q_full;

	// merge the byte at its position
	always_comb begin
		word  = group_q | ({24'b0, data_byte} << {~pos_q, 3'b000});
		close = (pos_q == 2'd3) || end_of_message;
	end

	assign q_push        = accept && close;
	assign q_entry.word  = word;
	assign q_entry.pos   = pos_q;
	assign q_entry.eom   = end_of_message;
	assign q_entry.zero  = (pos_q == 2'd3) && (word == 32'd0);

	// open group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= 32'd0;
			pos_q   <= 2'd0;
		end else if (accept) begin
			if (close) begin
				group_q <= 32'd0;
				pos_q   <= 2'd0;
			end else begin
				group_q <= word;
				pos_q   <= pos_q + 2'd1;
			end
		end
	end

endmodule

### rtl/a85_queue.sv
// a85_queue: short queue of closed groups between front and back
// depends on a85_pkg
module a85_queue
	import a85_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  grp_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic valid,
	output grp_t rd_data
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	grp_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/a85_conv.sv
// a85_conv: splits a group into five base-85 digits, one division by 85 a cycle
// depends on a85_pkg; reads a85_queue, hands digits to a85_emit
module a85_conv
	import a85_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  grp_t q_data,
	output logic q_pop,
	output logic h_valid,
	output dig_t h_data,
	input  logic h_take
);

	logic            busy_q;
	logic [1:0]      step_q;
	logic [31:0]     a_q;
	logic [31:0]     b_q;
	logic [2:0][6:0] dig_q;
	logic [1:0]      pos_q;
	logic            eom_q;
	logic            zero_q;
	logic [6:0]      rem;
	logic            done;
	logic            fire;
	logic            load;

	assign rem   = rem85(a_q, b_q);
	assign done  = busy_q && (step_q == 2'd3);
	assign fire  = done && h_take;
	assign load  = q_valid && (!busy_q || fire);
	assign q_pop = load;

	// handoff of the finished digit set
	assign h_valid           = done;
	assign h_data.digit[0]   = dig_q[0];
	assign h_data.digit[1]   = dig_q[1];
	assign h_data.digit[2]   = dig_q[2];
	assign h_data.digit[3]   = rem;
	assign h_data.digit[4]   = b_q[6:0];
	assign h_data.pos        = pos_q;
	assign h_data.eom        = eom_q;
	assign h_data.zero       = zero_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (!busy_q || fire) begin
			busy_q <= q_valid;
			step_q <= 2'd0;
		end else if (!done) begin
			step_q <= step_q + 2'd1;
		end
	end

	// datapath: a holds the dividend, b its quotient by 85
	always_ff @(posedge clk) begin
		if (load) begin
			a_q    <= q_data.word;
			b_q    <= div85(q_data.word);
			pos_q  <= q_data.pos;
			eom_q  <= q_data.eom;
			zero_q <= q_data.zero;
		end else if (busy_q && !done) begin
			dig_q[step_q] <= rem;
			a_q           <= b_q;
			b_q           <= div85(b_q);
		end
	end

endmodule

### rtl/a85_emit.sv
// a85_emit: maps digits through the alphabet and sends one character a cycle while pop keeps up
// depends on a85_pkg; fed by a85_conv, drives the result ports
module a85_emit
	import a85_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       alphabet_select,
	input  logic       h_valid,
	input  dig_t       h_data,
	output logic       h_take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       last_in_run,
	output logic       message_done
);

	logic            buf_valid_q;
	logic [4:0][6:0] dig_q;
	logic [2:0]      idx_q;
	logic [2:0]      last_idx_q;
	logic            eom_q;
	logic            zero_q;
	logic            out_valid_q;
	logic [7:0]      char_q;
	logic            last_q;
	logic            done_q;
	logic            adv;
	logic            is_last;
	logic [6:0]      cur_dig;
	logic [7:0]      cur_char;

	assign empty        = !out_valid_q;
	assign out_char     = char_q;
	assign last_in_run  = last_q;
	assign message_done = done_q;

	assign adv     = buf_valid_q && (!out_valid_q || pop);
	assign is_last = (idx_q == last_idx_q);
	assign h_take  = !buf_valid_q || (adv && is_last);

	// digits go out most significant first
	always_comb begin
		cur_dig = dig_q[3'd4 - idx_q];
		if (zero_q) begin
			cur_char = ZERO_CHAR;
		end else if (alphabet_select) begin
			cur_char = z85_char(cur_dig);
		end else begin
			cur_char = ASCII_BASE + {1'b0, cur_dig};
		end
	end

	// digit buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (h_take) begin
			buf_valid_q <= h_valid;
			idx_q       <= 3'd0;
		end else if (adv) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// digit buffer payload
	always_ff @(posedge clk) begin
		if (h_take && h_valid) begin
			dig_q      <= h_data.digit;
			eom_q      <= h_data.eom;
			zero_q     <= h_data.zero && !alphabet_select;
			last_idx_q <= (h_data.zero && !alphabet_select) ? 3'd0
				: {1'b0, h_data.pos} + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= cur_char;
			last_q <= is_last;
			done_q <= is_last && eom_q;
		end
	end

endmodule

### rtl/ascii85_encoder.sv
// ascii85_encoder: top level of the streaming ascii85 / z85 encoder
// depends on a85_pkg, a85_front, a85_queue, a85_conv, a85_emit
//
//  channel   ports                                        transfer when
//  input     push full data_byte end_of_message           push && !full
//  result    pop empty out_char last_in_run message_done  pop && !empty
//  config    cfg_we cfg_wdata (alphabet_select)           cfg_we
//
// a byte is taken every cycle while the group queue has room; a closing byte
// queues its group. the divider does one division by 85 a cycle, holds its
// digits until the emitter takes them and then loads the next group; the
// emitter sends one character a cycle, up to five per group, while pop keeps up.
// reset clears the open group, the queue, both back stages and the register.
// a stalled result side fills the output register, digit buffer, divider and
// queue in turn before full rises.
module ascii85_encoder
	import a85_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       last_in_run,
	output logic       message_done,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic alphabet_select_q;
	logic q_full;
	logic q_push;
	grp_t q_entry;
	logic q_valid;
	logic q_pop;
	grp_t q_head;
	logic h_valid;
	dig_t h_data;
	logic h_take;

	// alphabet register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_select_q <= 1'b0;
		end else if (cfg_we) begin
			alphabet_select_q <= cfg_wdata;
		end
	end

	a85_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_entry)
	);

	a85_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_entry),
		.full    (q_full),
		.rd_en   (q_pop),
		.valid   (q_valid),
		.rd_data (q_head)
	);

	a85_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_head),
		.q_pop   (q_pop),
		.h_valid (h_valid),
		.h_data  (h_data),
		.h_take  (h_take)
	);

	a85_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.alphabet_select (alphabet_select_q),
		.h_valid         (h_valid),
		.h_data          (h_data),
		.h_take          (h_take),
		.empty           (empty),
		.pop             (pop),
		.out_char        (out_char),
		.last_in_run     (last_in_run),
		.message_done    (message_done)
	);

endmodule
